/* hw/rtl/dotq_pkg.sv */
// dotq_pkg: types, widths and codes shared by the deadline ordered task queue
// used by dotq_ctrl, dotq_datapath and deadline_ordered_task_queue; no dependencies
`timescale 1ns / 1ps

package dotq_pkg;

	localparam int DEPTH = 16;
	localparam int CntW = $clog2(DEPTH + 1);

	localparam int OpW = 2;
	localparam int IdW = 8;
	localparam int DlW = 32;
	localparam int StatusW = 2;
	localparam int TaskCountW = 5;

	localparam int InBits = OpW + IdW + DlW;
	localparam int InDataW = ((InBits + 7) / 8) * 8;
	localparam int OutBits = StatusW + 1 + 1 + IdW + DlW + TaskCountW;
	localparam int OutDataW = ((OutBits + 7) / 8) * 8;

	// operation codes; the unused code behaves as a query
	localparam logic [OpW-1:0] OP_INSERT = 2'd0;
	localparam logic [OpW-1:0] OP_REMOVE = 2'd1;
	localparam logic [OpW-1:0] OP_QUERY = 2'd2;

	// status codes
	localparam logic [StatusW-1:0] ST_OK = 2'd0;
	localparam logic [StatusW-1:0] ST_FULL = 2'd1;
	localparam logic [StatusW-1:0] ST_NOT_FOUND = 2'd2;
	localparam logic [StatusW-1:0] ST_DUPLICATE = 2'd3;

	typedef enum logic {
		S_IDLE,
		S_EXEC
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic commit;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic out_busy;
	} stat_t;

endpackage

/* hw/rtl/deadline_ordered_task_queue.sv */
// deadline_ordered_task_queue: top level, stream ports around controller and datapath
// depends on dotq_pkg, dotq_ctrl and dotq_datapath
`timescale 1ns / 1ps

// earliest-deadline-first ready queue holding up to dotq_pkg::DEPTH tasks (id and
// deadline), kept in rising deadline order with equal deadlines in insert order.
// each request carries insert, remove by id, or query (the spare code acts as a
// query), and each request returns exactly one response with status, membership,
// head task, head deadline and count as they stand after the request. a request
// is accepted in S_IDLE, then goes through the compare-and-shift slot array in
// S_EXEC, where every slot compares its id and deadline at once and moves by at
// most one place. the response register lets the next request be accepted while a
// response waits; a request only stalls in S_EXEC while the previous response is
// unclaimed. slot contents hold no reset; reset clears the count and response valid.

module deadline_ordered_task_queue (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// operation[1:0], task_id[9:2], deadline[41:10], zero fill above
	input  logic [dotq_pkg::InDataW-1:0]      s_axis_tdata,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// status[1:0], is_present[2], head_valid[3], head_task[11:4],
	// head_deadline[43:12], task_count[48:44], zero fill above
	output logic [dotq_pkg::OutDataW-1:0]     m_axis_tdata
);

	dotq_pkg::cmd_t cmd;
	dotq_pkg::stat_t stat;

	logic [dotq_pkg::StatusW-1:0] status;
	logic is_present;
	logic head_valid;
	logic [dotq_pkg::IdW-1:0] head_task;
	logic [dotq_pkg::DlW-1:0] head_deadline;
	logic [dotq_pkg::TaskCountW-1:0] task_count;

	dotq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (s_axis_tvalid),
		.req_ready (s_axis_tready),
		.stat      (stat),
		.cmd       (cmd)
	);

	dotq_datapath u_datapath (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.stat              (stat),
		.in_operation      (s_axis_tdata[1:0]),
		.in_task_id        (s_axis_tdata[9:2]),
		.in_deadline       (s_axis_tdata[41:10]),
		.out_valid         (m_axis_tvalid),
		.out_ready         (m_axis_tready),
		.out_status        (status),
		.out_is_present    (is_present),
		.out_head_valid    (head_valid),
		.out_head_task     (head_task),
		.out_head_deadline (head_deadline),
		.out_task_count    (task_count)
	);

	// pack the response fields, highest field first
	assign m_axis_tdata = {
		(dotq_pkg::OutDataW - dotq_pkg::OutBits)'(0),
		task_count,
		head_deadline,
		head_task,
		head_valid,
		is_present,
		status
	};

endmodule

/* hw/rtl/dotq_ctrl.sv */
// dotq_ctrl: sequencing state machine of the deadline ordered task queue
// depends on dotq_pkg
`timescale 1ns / 1ps

module dotq_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_ready,
	input  dotq_pkg::stat_t  stat,
	output dotq_pkg::cmd_t   cmd
);

	dotq_pkg::state_t state_q;
	dotq_pkg::state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dotq_pkg::S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		req_ready = 1'b0;
		cmd = '0;
		unique case (state_q)
			dotq_pkg::S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.load = 1'b1;
					state_nxt = dotq_pkg::S_EXEC;
				end
			end
			dotq_pkg::S_EXEC: begin
				// wait here while the previous response is still unclaimed
				if (!stat.out_busy) begin
					cmd.commit = 1'b1;
					state_nxt = dotq_pkg::S_IDLE;
				end
			end
			default: begin
				state_nxt = dotq_pkg::S_IDLE;
			end
		endcase
	end

endmodule

/* hw/rtl/dotq_datapath.sv */
// dotq_datapath: request registers, compare-and-shift slot array, response register
// depends on dotq_pkg; driven by dotq_ctrl
`timescale 1ns / 1ps

module dotq_datapath (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  dotq_pkg::cmd_t                       cmd,
	output dotq_pkg::stat_t                      stat,
	input  logic [dotq_pkg::OpW-1:0]             in_operation,
	input  logic [dotq_pkg::IdW-1:0]             in_task_id,
	input  logic [dotq_pkg::DlW-1:0]             in_deadline,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [dotq_pkg::StatusW-1:0]         out_status,
	output logic                                 out_is_present,
	output logic                                 out_head_valid,
	output logic [dotq_pkg::IdW-1:0]             out_head_task,
	output logic [dotq_pkg::DlW-1:0]             out_head_deadline,
	output logic [dotq_pkg::TaskCountW-1:0]      out_task_count
);

	// latched request
	logic [dotq_pkg::OpW-1:0] op_q;
	logic [dotq_pkg::IdW-1:0] id_q;
	logic [dotq_pkg::DlW-1:0] dl_q;

	// slot array, slot 0 is the head
	logic [dotq_pkg::IdW-1:0] slot_task_q [dotq_pkg::DEPTH];
	logic [dotq_pkg::DlW-1:0] slot_deadline_q [dotq_pkg::DEPTH];
	logic [dotq_pkg::CntW-1:0] count_q;

	logic [dotq_pkg::IdW-1:0] task_nxt [dotq_pkg::DEPTH];
	logic [dotq_pkg::DlW-1:0] deadline_nxt [dotq_pkg::DEPTH];
	logic [dotq_pkg::CntW-1:0] count_nxt;

	logic [dotq_pkg::DEPTH-1:0] occ_vec;
	logic [dotq_pkg::DEPTH-1:0] match_vec;
	logic [dotq_pkg::DEPTH-1:0] le_vec;
	logic found;
	logic full;
	logic is_ins;
	logic is_rem;
	logic do_ins;
	logic do_rem;
	logic [dotq_pkg::StatusW-1:0] status_nxt;

	// response register
	logic out_valid_q;
	logic [dotq_pkg::StatusW-1:0] out_status_q;
	logic out_present_q;
	logic out_head_valid_q;
	logic [dotq_pkg::IdW-1:0] out_head_task_q;
	logic [dotq_pkg::DlW-1:0] out_head_deadline_q;
	logic [dotq_pkg::TaskCountW-1:0] out_count_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= in_operation;
			id_q <= in_task_id;
			dl_q <= in_deadline;
		end
	end

	// per-slot compares, all slots in parallel
	always_comb begin
		for (int i = 0; i < dotq_pkg::DEPTH; i++) begin
			occ_vec[i] = dotq_pkg::CntW'(i) < count_q;
			match_vec[i] = occ_vec[i] && (slot_task_q[i] == id_q);
			le_vec[i] = occ_vec[i] && (slot_deadline_q[i] <= dl_q);
		end
		found = |match_vec;
		full = count_q >= dotq_pkg::CntW'(dotq_pkg::DEPTH);
		is_ins = op_q == dotq_pkg::OP_INSERT;
		is_rem = op_q == dotq_pkg::OP_REMOVE;
	end

	always_comb begin
		priority if (is_ins) begin
			priority if (found) status_nxt = dotq_pkg::ST_DUPLICATE;
			else if (full) status_nxt = dotq_pkg::ST_FULL;
			else status_nxt = dotq_pkg::ST_OK;
		end else begin
			status_nxt = found ? dotq_pkg::ST_OK : dotq_pkg::ST_NOT_FOUND;
		end
		do_ins = is_ins && !found && !full;
		do_rem = is_rem && found;
	end

	// next slot contents: insert shifts the tail down, remove closes the gap
	always_comb begin
		logic prev_le;
		logic gone;
		logic [dotq_pkg::IdW-1:0] prev_task;
		logic [dotq_pkg::DlW-1:0] prev_dl;
		prev_le = 1'b1;
		gone = 1'b0;
		prev_task = '0;
		prev_dl = '0;
		count_nxt = count_q;
		for (int i = 0; i < dotq_pkg::DEPTH; i++) begin
			task_nxt[i] = slot_task_q[i];
			deadline_nxt[i] = slot_deadline_q[i];
		end
		if (do_ins) begin
			count_nxt = count_q + 1'b1;
			for (int i = 0; i < dotq_pkg::DEPTH; i++) begin
				if (!le_vec[i]) begin
					if (prev_le) begin
						task_nxt[i] = id_q;
						deadline_nxt[i] = dl_q;
					end else begin
						task_nxt[i] = prev_task;
						deadline_nxt[i] = prev_dl;
					end
				end
				prev_le = le_vec[i];
				prev_task = slot_task_q[i];
				prev_dl = slot_deadline_q[i];
			end
		end
		if (do_rem) begin
			count_nxt = count_q - 1'b1;
			for (int i = 0; i < dotq_pkg::DEPTH - 1; i++) begin
				gone = gone | match_vec[i];
				if (gone) begin
					task_nxt[i] = slot_task_q[i+1];
					deadline_nxt[i] = slot_deadline_q[i+1];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			for (int i = 0; i < dotq_pkg::DEPTH; i++) begin
				slot_task_q[i] <= task_nxt[i];
				slot_deadline_q[i] <= deadline_nxt[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.commit) begin
				count_q <= count_nxt;
			end
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// a removed id is gone afterwards, a fresh insert is held afterwards
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			out_status_q <= status_nxt;
			out_present_q <= (found && !is_rem) || do_ins;
			out_head_valid_q <= count_nxt != '0;
			out_head_task_q <= (count_nxt != '0) ? task_nxt[0] : '0;
			out_head_deadline_q <= (count_nxt != '0) ? deadline_nxt[0] : '0;
			out_count_q <= dotq_pkg::TaskCountW'(count_nxt);
		end
	end

	assign stat.out_busy = out_valid_q && !out_ready;
	assign out_valid = out_valid_q;
	assign out_status = out_status_q;
	assign out_is_present = out_present_q;
	assign out_head_valid = out_head_valid_q;
	assign out_head_task = out_head_task_q;
	assign out_head_deadline = out_head_deadline_q;
	assign out_task_count = out_count_q;

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= dotq_pkg::CntW'(dotq_pkg::DEPTH))
		else $error("held count beyond depth");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> !(out_valid_q && !out_ready))
		else $error("response overwritten before it was taken");

	a_commit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> out_valid_q)
		else $error("committed request produced no response");

	a_count_only_on_commit: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.commit |=> $stable(count_q))
		else $error("count changed without a commit");

	a_head_ordered: assert property (@(posedge clk) disable iff (!arst_n)
		count_q >= dotq_pkg::CntW'(2) |-> slot_deadline_q[0] <= slot_deadline_q[1])
		else $error("head deadline above second slot");
`endif

endmodule
